[src/trouble_code_blink_out_assert.svh]
// ----------------------------------------------------------------------------
// trouble code blink out assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TROUBLE_CODE_BLINK_OUT_ASSERT_SVH
`define TROUBLE_CODE_BLINK_OUT_ASSERT_SVH

`ifndef SYNTH
// check sampled on clk, off while rst is high
`define TCBO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("trouble_code_blink_out: check failed");
// check sampled on clk, also during reset
`define TCBO_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("trouble_code_blink_out: check failed");
`else
`define TCBO_ASSERT(label, prop)
`define TCBO_ASSERT_NR(label, prop)
`endif

`endif

[src/tcbo_pkg.sv]
// ----------------------------------------------------------------------------
// tcbo_pkg
// types and constants of the trouble code blink out block
// ----------------------------------------------------------------------------
package tcbo_pkg;

  localparam int CODE_W    = 16;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int COUNT_IN_W = 5;
  localparam int INDEX_W   = 4;
  localparam int NUM_BCD   = 5;   // decimal digits of a 16-bit code
  localparam int BCD_W     = 4 * NUM_BCD;
  localparam int PLACE_W   = 3;
  localparam int PULSES_W  = 4;
  localparam int CFG_ADDR_W = 3;

  localparam logic [DUR_W-1:0] SHORT_PULSE_RST = 16'd400;
  localparam logic [DUR_W-1:0] LONG_PULSE_RST  = 16'd1500;
  localparam logic [DUR_W-1:0] GAP_RST         = 16'd400;
  localparam logic [DUR_W-1:0] ESC_PERIOD_RST  = 16'd200;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_COUNT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHORT_PULSE = 3'd0,
    REG_LONG_PULSE  = 3'd1,
    REG_GAP         = 3'd2,
    REG_ESC_PERIOD  = 3'd3,
    REG_KOEO_ENABLE = 3'd4
  } reg_index_t;

endpackage

[src/trouble_code_blink_out.sv]
// ----------------------------------------------------------------------------
// trouble_code_blink_out
// blinks stored trouble codes on a warning lamp, one decimal digit at a time
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   s_tuser kind, s_tdata tick and table fields
//  m_*       out  m_tvalid / m_tready   m_tdata lamp_on, current_code, blink_phase
//  cfg_*     in   cfg_we                cfg_addr register index, cfg_data value
//
//  one item at a time: s_tready is high only in the idle state
//  writes and non-blinking ticks pass through accept, decide and output handoff
//  a blinking tick scans the table, reading then comparing one slot at a time
//  a new code adds a fetch, a load and a 16-step decimal shift
//  a stalled m_tready holds only the handoff; the next item is taken once it loads
//  reset clears control state; code table entries are defined once written
//
module trouble_code_blink_out #(
  parameter int MAX_CODES  = 16,
  parameter int MAX_DIGITS = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] now_ms, [32] ignition_on, [33] bench_override,
  // [34] escalation_active, [35] engine_stopped, [39:36] entry_index,
  // [55:40] entry_code, [60:56] new_count, [63:61] zero
  input  logic [63:0]                      s_tdata,
  // [1:0] kind
  input  logic [1:0]                       s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] lamp_on, [16:1] current_code, [18:17] blink_phase, [23:19] zero
  output logic [23:0]                      m_tdata,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [tcbo_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tcbo_pkg::DUR_W-1:0]       cfg_data
);

  import tcbo_pkg::*;

  `include "trouble_code_blink_out_assert.svh"

  // table address and count widths follow the table depth
  localparam int AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int CW = $clog2(MAX_CODES + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DECIDE  = 10'b00_0000_0010,
    S_READ    = 10'b00_0000_0100,
    S_COMPARE = 10'b00_0000_1000,
    S_TIME    = 10'b00_0001_0000,
    S_FETCH   = 10'b00_0010_0000,
    S_LOAD    = 10'b00_0100_0000,
    S_CONVERT = 10'b00_1000_0000,
    S_START   = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [DUR_W-1:0] short_pulse_ms;
  logic [DUR_W-1:0] long_pulse_ms;
  logic [DUR_W-1:0] gap_ms;
  logic [DUR_W-1:0] escalation_period_ms;
  logic             koeo_check_enable;

  // latched input item
  logic [1:0]            in_kind;
  logic [TIME_W-1:0]     in_now;
  logic                  in_ignition;
  logic                  in_bench;
  logic                  in_escalation;
  logic                  in_stopped;
  logic [INDEX_W-1:0]    in_entry_index;
  logic [CODE_W-1:0]     in_entry_code;
  logic [COUNT_IN_W-1:0] in_new_count;

  // blink sequence state
  logic [CW-1:0]       code_count;
  phase_t              phase;
  logic [CODE_W-1:0]   active_code;
  logic [PLACE_W-1:0]  digit_place;
  logic [PULSES_W-1:0] pulses_left;
  logic [TIME_W-1:0]   phase_start_ms;
  logic                bench_was_active;
  logic                was_escalating;
  logic                flash_level;
  logic [TIME_W-1:0]   flash_start_ms;
  logic                lamp_level;

  // code table and its read port
  logic [CODE_W-1:0] code_table [MAX_CODES];
  logic [AW-1:0]     rd_addr;
  logic [CODE_W-1:0] rd_data;
  logic              tbl_we;
  logic [AW-1:0]     wr_addr;

  // scan and decimal conversion
  logic [AW-1:0]     scan_idx;
  logic [AW-1:0]     nxt_idx;
  logic              scan_hit;
  logic              scan_last;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CODE_W-1:0] bin;
  logic [3:0]        bit_cnt;
  logic [3:0]        digit [NUM_BCD];
  logic [PLACE_W-1:0] top_place;
  logic [PLACE_W-1:0] place_dn;

  // shared elapsed-time compare
  logic [TIME_W-1:0] tm_start;
  logic [DUR_W-1:0]  tm_dur;
  logic              tm_over;

  // output register
  logic               out_lamp;
  logic [CODE_W-1:0]  out_code;
  phase_t             out_phase;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {5'd0, out_phase, out_code, out_lamp};

  // ---------------------------------------------------------------------------
  // code table: one write port (kind 1 items), one registered read port
  // ---------------------------------------------------------------------------
  assign tbl_we  = (state == S_DECIDE) && (kind_t'(in_kind) == KIND_WRITE) &&
                   (int'(in_entry_index) < MAX_CODES);
  assign wr_addr = AW'(in_entry_index);
  assign rd_addr = (state == S_FETCH) ? nxt_idx : scan_idx;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      code_table[wr_addr] <= in_entry_code;
    end
    rd_data <= code_table[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // one subtract and compare serves the flash timer and the blink timer
  // a timer has run out when the wrapped elapsed time exceeds the duration
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state == S_DECIDE) begin
      tm_start = flash_start_ms;
      tm_dur   = escalation_period_ms;
    end else begin
      tm_start = phase_start_ms;
      if (phase == PH_PULSE) begin
        tm_dur = digit_place[0] ? long_pulse_ms : short_pulse_ms;
      end else begin
        tm_dur = gap_ms;
      end
    end
    tm_over = (in_now - tm_start) > TIME_W'(tm_dur);
  end

  // table scan compare
  assign scan_hit  = (rd_data == active_code);
  assign scan_last = ((CW'(scan_idx) + CW'(1)) == code_count);

  // ---------------------------------------------------------------------------
  // decimal digits: shift-and-add-3 step, digit view and leading place
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      digit[i] = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                   : bcd[4*i +: 4];
    end
  end

  // highest nonzero place, capped to the number of places shown
  always_comb begin
    top_place = '0;
    for (int i = 1; i < NUM_BCD; i++) begin
      if (digit[i] != 4'd0) begin
        top_place = PLACE_W'(i);
      end
    end
    if (top_place > PLACE_W'(MAX_DIGITS - 1)) begin
      top_place = PLACE_W'(MAX_DIGITS - 1);
    end
  end

  assign place_dn = digit_place - PLACE_W'(1);

  // ---------------------------------------------------------------------------
  // input latch (payload, no reset)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind        <= s_tuser;
      in_now         <= s_tdata[31:0];
      in_ignition    <= s_tdata[32];
      in_bench       <= s_tdata[33];
      in_escalation  <= s_tdata[34];
      in_stopped     <= s_tdata[35];
      in_entry_index <= s_tdata[39:36];
      in_entry_code  <= s_tdata[55:40];
      in_new_count   <= s_tdata[60:56];
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      short_pulse_ms       <= SHORT_PULSE_RST;
      long_pulse_ms        <= LONG_PULSE_RST;
      gap_ms               <= GAP_RST;
      escalation_period_ms <= ESC_PERIOD_RST;
      koeo_check_enable    <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_SHORT_PULSE: short_pulse_ms       <= cfg_data;
        REG_LONG_PULSE:  long_pulse_ms        <= cfg_data;
        REG_GAP:         gap_ms               <= cfg_data;
        REG_ESC_PERIOD:  escalation_period_ms <= cfg_data;
        REG_KOEO_ENABLE: koeo_check_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // decimal conversion registers (payload)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      bcd <= '0;
      bin <= rd_data;
    end else if (state == S_CONVERT) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[CODE_W-1]};
      bin <= {bin[CODE_W-2:0], 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and blink state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      code_count       <= '0;
      phase            <= PH_IDLE;
      active_code      <= '0;
      digit_place      <= '0;
      pulses_left      <= '0;
      phase_start_ms   <= '0;
      bench_was_active <= 1'b0;
      was_escalating   <= 1'b0;
      flash_level      <= 1'b0;
      flash_start_ms   <= '0;
      lamp_level       <= 1'b0;
      scan_idx         <= '0;
      nxt_idx          <= '0;
      bit_cnt          <= '0;
      m_tvalid         <= 1'b0;
      out_lamp         <= 1'b0;
      out_code         <= '0;
      out_phase        <= PH_IDLE;
    end else begin
      // result taken downstream; a load in S_EMIT keeps it valid instead
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          case (kind_t'(in_kind))
            KIND_TICK: begin
              if (in_bench) begin
                // bench drives the real lamp, hold everything
                bench_was_active <= 1'b1;
                state            <= S_EMIT;
              end else begin
                // the first tick after bench override starts from idle
                bench_was_active <= 1'b0;
                if (!in_ignition) begin
                  phase       <= PH_IDLE;
                  active_code <= '0;
                  lamp_level  <= 1'b0;
                  state       <= S_EMIT;
                end else if (in_escalation) begin
                  // plain flashing, starts lit
                  phase       <= PH_IDLE;
                  active_code <= '0;
                  state       <= S_EMIT;
                  if (!was_escalating) begin
                    was_escalating <= 1'b1;
                    flash_level    <= 1'b1;
                    flash_start_ms <= in_now;
                    lamp_level     <= 1'b1;
                  end else if (tm_over) begin
                    flash_level    <= ~flash_level;
                    flash_start_ms <= in_now;
                    lamp_level     <= ~flash_level;
                  end else begin
                    lamp_level <= flash_level;
                  end
                end else begin
                  was_escalating <= 1'b0;
                  if (code_count == '0) begin
                    // key-on bulb check
                    phase       <= PH_IDLE;
                    active_code <= '0;
                    lamp_level  <= koeo_check_enable & in_stopped;
                    state       <= S_EMIT;
                  end else begin
                    if (bench_was_active) begin
                      phase       <= PH_IDLE;
                      active_code <= '0;
                    end
                    // look up the active code in the table
                    scan_idx <= '0;
                    state    <= S_READ;
                  end
                end
              end
            end
            KIND_COUNT: begin
              if (int'(in_new_count) > MAX_CODES) begin
                code_count <= CW'(MAX_CODES);
              end else begin
                code_count <= CW'(in_new_count);
              end
              state <= S_EMIT;
            end
            default: begin
              state <= S_EMIT;
            end
          endcase
        end

        S_READ: begin
          state <= S_COMPARE;
        end

        S_COMPARE: begin
          if (scan_hit || scan_last) begin
            // successor slot wraps to the first; a missing code restarts at slot 0
            nxt_idx <= (scan_hit && !scan_last) ? scan_idx + AW'(1) : '0;
            if (!scan_hit || phase == PH_IDLE) begin
              state <= S_FETCH;
            end else begin
              state <= S_TIME;
            end
          end else begin
            scan_idx <= scan_idx + AW'(1);
            state    <= S_READ;
          end
        end

        S_TIME: begin
          if (phase == PH_PULSE) begin
            state <= S_EMIT;
            if (tm_over) begin
              lamp_level     <= 1'b0;
              phase          <= PH_GAP;
              phase_start_ms <= in_now;
            end
          end else if (!tm_over) begin
            state <= S_EMIT;
          end else if (pulses_left > PULSES_W'(1)) begin
            pulses_left    <= pulses_left - PULSES_W'(1);
            lamp_level     <= 1'b1;
            phase          <= PH_PULSE;
            phase_start_ms <= in_now;
            state          <= S_EMIT;
          end else if (digit_place != '0) begin
            // next lower digit
            digit_place    <= place_dn;
            pulses_left    <= digit[place_dn] + 4'd1;
            lamp_level     <= 1'b1;
            phase          <= PH_PULSE;
            phase_start_ms <= in_now;
            state          <= S_EMIT;
          end else begin
            // code finished, move on to the next slot
            state <= S_FETCH;
          end
        end

        S_FETCH: begin
          state <= S_LOAD;
        end

        S_LOAD: begin
          active_code <= rd_data;
          bit_cnt     <= '0;
          state       <= S_CONVERT;
        end

        S_CONVERT: begin
          bit_cnt <= bit_cnt + 4'd1;
          if (bit_cnt == 4'd15) begin
            state <= S_START;
          end
        end

        S_START: begin
          // first pulse of the leading digit
          digit_place    <= top_place;
          pulses_left    <= digit[top_place] + 4'd1;
          lamp_level     <= 1'b1;
          phase          <= PH_PULSE;
          phase_start_ms <= in_now;
          state          <= S_EMIT;
        end

        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            out_lamp  <= lamp_level;
            out_code  <= active_code;
            out_phase <= phase;
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `TCBO_ASSERT_NR(a_pulse_lit, (phase == PH_PULSE) |-> lamp_level)
  `TCBO_ASSERT_NR(a_gap_dark, (phase == PH_GAP) |-> !lamp_level)
  `TCBO_ASSERT(a_busy_after_transfer, (s_tvalid && s_tready) |=> !s_tready)
  `TCBO_ASSERT(a_pulses_left, (phase != PH_IDLE) |-> (pulses_left != '0))

endmodule

[bench/trouble_code_blink_out_tb.sv]
// ----------------------------------------------------------------------------
// trouble_code_blink_out_tb
// self-checking bench: directed rows, then random tick and table traffic under
// several register settings; each result is checked against a hand-written
// expectation or, where the row has none, against an in-bench model
module trouble_code_blink_out_tb;
  import tcbo_pkg::*;

  localparam int SLOTS        = 16;
  localparam int DIGITS       = 5;
  localparam int LIMIT_CYCLES = 1_000_000;  // watchdog bound for the whole run
  localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
  localparam int PHASE_ITEMS  = 216;
  localparam int CALM_ITEMS   = 150;        // tail of the run without idling

  // kind 3 has no meaning in the block, it must change nothing
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // tick flag masks for the directed rows
  localparam logic [3:0] F_IGN   = 4'b0001;
  localparam logic [3:0] F_BENCH = 4'b0010;
  localparam logic [3:0] F_ESC   = 4'b0100;
  localparam logic [3:0] F_STOP  = 4'b1000;

  typedef struct packed {
    logic        lamp;
    logic [15:0] code;
    phase_t      ph;
  } lamp_result_t;

  typedef struct {
    logic [1:0]   kind;
    logic [31:0]  now;
    bit           ign;
    bit           bench;
    bit           esc;
    bit           stopped;
    logic [3:0]   idx;
    logic [15:0]  code;
    logic [4:0]   cnt;
    bit           typed;   // row carries a hand-written expectation
    lamp_result_t want;
  } blink_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [31:0] now_ms, [32] ignition_on, [33] bench_override,
  // [34] escalation_active, [35] engine_stopped, [39:36] entry_index,
  // [55:40] entry_code, [60:56] new_count, [63:61] zero
  logic [63:0] s_tdata;
  // [1:0] kind
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // [0] lamp_on, [16:1] current_code, [18:17] blink_phase, [23:19] zero
  logic [23:0] m_tdata;
  logic        cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DUR_W-1:0]      cfg_data;

  trouble_code_blink_out #(
    .MAX_CODES (SLOTS),
    .MAX_DIGITS(DIGITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // lamp model: register copies and blink sequence state
  // --------------------------------------------------------------------------
  logic [15:0] cfg_short, cfg_long, cfg_gap, cfg_flash;
  bit          cfg_koeo;

  logic [15:0] tbl [SLOTS];      // only written slots are ever read
  logic [4:0]  tbl_count;
  phase_t      seq_ph;
  logic [15:0] seq_code;
  logic [13:0] seq_div;
  logic [2:0]  seq_place;
  logic [3:0]  seq_pulses;
  logic [31:0] seq_t0;
  bit          bench_seen;
  bit          esc_seen;
  bit          flash_lvl;
  logic [31:0] flash_t0;
  bit          lamp_lvl;

  lamp_result_t pending_lamp_q[$];
  int           err_count = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;      // no idling on either side
  bit           hold_req = 1'b0;  // ask the receiver for a long hold-off

  // random tick generator state
  logic [31:0] clock_ms;
  int unsigned esc_left, bench_left, off_left;

  function automatic void clear_lamp_model();
    cfg_short  = SHORT_PULSE_RST;
    cfg_long   = LONG_PULSE_RST;
    cfg_gap    = GAP_RST;
    cfg_flash  = ESC_PERIOD_RST;
    cfg_koeo   = 1'b0;
    tbl_count  = '0;
    seq_ph     = PH_IDLE;
    seq_code   = '0;
    seq_div    = 14'd1;
    seq_place  = '0;
    seq_pulses = '0;
    seq_t0     = '0;
    bench_seen = 1'b0;
    esc_seen   = 1'b0;
    flash_lvl  = 1'b0;
    flash_t0   = '0;
    lamp_lvl   = 1'b0;
  endfunction

  // timer test on wrapped 32-bit time, strictly greater than the duration
  function automatic bit timed_out(logic [31:0] now, logic [31:0] t0, logic [15:0] dur);
    logic [31:0] span;
    span = now - t0;
    return span > {16'd0, dur};
  endfunction

  function automatic void seq_idle();
    seq_ph   = PH_IDLE;
    seq_code = '0;
  endfunction

  function automatic void start_pulse(logic [31:0] now);
    lamp_lvl = 1'b1;
    seq_ph   = PH_PULSE;
    seq_t0   = now;
  endfunction

  function automatic void start_digit(logic [31:0] now);
    int div;
    div = (seq_div == 0) ? 1 : int'(seq_div);
    seq_pulses = 4'((int'(seq_code) / div) % 10 + 1);
    start_pulse(now);
  endfunction

  // most significant shown place first, capped at the digit limit
  function automatic void start_code(logic [15:0] code, logic [31:0] now);
    int v, n;
    seq_code  = code;
    seq_div   = 14'd1;
    seq_place = '0;
    v = code;
    n = 0;
    while (v >= 10 && n + 1 < DIGITS) begin
      v = v / 10;
      seq_div = seq_div * 14'd10;
      seq_place++;
      n++;
    end
    start_digit(now);
  endfunction

  function automatic bit code_listed();
    for (int i = 0; i < int'(tbl_count) && i < SLOTS; i++)
      if (tbl[i] == seq_code) return 1'b1;
    return 1'b0;
  endfunction

  // next slot after the active code, slot 0 if the code is gone
  function automatic void advance_code(logic [31:0] now);
    int nxt;
    nxt = 0;
    if (tbl_count == 0) begin
      seq_idle();
      return;
    end
    for (int i = 0; i < int'(tbl_count) && i < SLOTS; i++) begin
      if (tbl[i] == seq_code) begin
        nxt = (i + 1) % int'(tbl_count);
        break;
      end
    end
    start_code(tbl[nxt], now);
  endfunction

  function automatic void tick_model(blink_item_t it);
    logic [15:0] dur;
    if (it.bench) begin
      // bench drives the real lamp, our level is only held
      bench_seen = 1'b1;
      return;
    end
    if (bench_seen) begin
      bench_seen = 1'b0;
      seq_idle();
    end
    if (!it.ign) begin
      seq_idle();
      lamp_lvl = 1'b0;
      return;
    end
    if (it.esc) begin
      // plain flashing, starts lit
      if (!esc_seen) begin
        esc_seen  = 1'b1;
        flash_lvl = 1'b1;
        flash_t0  = it.now;
      end
      seq_idle();
      if (timed_out(it.now, flash_t0, cfg_flash)) begin
        flash_lvl = ~flash_lvl;
        flash_t0  = it.now;
      end
      lamp_lvl = flash_lvl;
      return;
    end
    esc_seen = 1'b0;
    if (tbl_count == 0) begin
      // key-on bulb check
      seq_idle();
      lamp_lvl = cfg_koeo && it.stopped;
      return;
    end
    if (seq_ph == PH_IDLE || !code_listed()) begin
      advance_code(it.now);
      return;
    end
    if (seq_ph == PH_PULSE) begin
      dur = seq_place[0] ? cfg_long : cfg_short;
      if (timed_out(it.now, seq_t0, dur)) begin
        lamp_lvl = 1'b0;
        seq_ph   = PH_GAP;
        seq_t0   = it.now;
      end
      return;
    end
    if (!timed_out(it.now, seq_t0, cfg_gap)) return;
    if (seq_pulses > 1) begin
      seq_pulses--;
      start_pulse(it.now);
    end else if (seq_div > 1) begin
      seq_pulses = '0;
      seq_div    = seq_div / 14'd10;
      seq_place  = seq_place - 3'd1;
      start_digit(it.now);
    end else begin
      seq_pulses = '0;
      advance_code(it.now);
    end
  endfunction

  function automatic lamp_result_t predict_lamp(blink_item_t it);
    lamp_result_t r;
    case (it.kind)
      KIND_TICK:  tick_model(it);
      KIND_WRITE: tbl[it.idx] = it.code;
      KIND_COUNT: tbl_count = (it.cnt > SLOTS) ? 5'(SLOTS) : it.cnt;
      default: ;
    endcase
    r.lamp = lamp_lvl;
    r.code = seq_code;
    r.ph   = seq_ph;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic blink_item_t row(logic [1:0] k, logic [31:0] t, logic [3:0] fl,
                                      logic [3:0] ix, logic [15:0] cd, logic [4:0] n);
    blink_item_t r;
    r.kind    = k;
    r.now     = t;
    r.ign     = fl[0];
    r.bench   = fl[1];
    r.esc     = fl[2];
    r.stopped = fl[3];
    r.idx     = ix;
    r.code    = cd;
    r.cnt     = n;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic blink_item_t with_result(blink_item_t r, bit lamp, logic [15:0] cd,
                                              phase_t ph);
    r.typed     = 1'b1;
    r.want.lamp = lamp;
    r.want.code = cd;
    r.want.ph   = ph;
    return r;
  endfunction

  // mix of single digits, short codes and full 16-bit values
  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(10, 999));
      2:       return 16'($urandom_range(10000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed ticks moving forward in time, with runs of escalation,
  // bench override and ignition off, plus table and count writes
  task automatic draw_item(output blink_item_t it, input int unsigned dt_max);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = row(KIND_TICK, $urandom, 4'($urandom), 4'($urandom), 16'($urandom), 5'($urandom));
    if (pick < 80) begin
      if ($urandom_range(0, 63) == 0) clock_ms = $urandom;  // time jump
      else clock_ms = clock_ms + $urandom_range(0, dt_max);
      if (esc_left == 0 && $urandom_range(0, 39) == 0) esc_left = $urandom_range(1, 8);
      if (bench_left == 0 && $urandom_range(0, 49) == 0) bench_left = $urandom_range(1, 4);
      if (off_left == 0 && $urandom_range(0, 29) == 0) off_left = $urandom_range(1, 3);
      it.now     = clock_ms;
      it.ign     = (off_left == 0);
      it.bench   = (bench_left != 0);
      it.esc     = (esc_left != 0);
      it.stopped = $urandom_range(0, 1);
      if (esc_left != 0) esc_left--;
      if (bench_left != 0) bench_left--;
      if (off_left != 0) off_left--;
    end else if (pick < 88) begin
      it.kind = KIND_WRITE;
      it.code = pick_code();
    end else if (pick < 96) begin
      it.kind = KIND_COUNT;
      // counts above the table size saturate
      it.cnt  = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, SLOTS))
                                            : 5'($urandom_range(0, 31));
    end else begin
      it.kind = KIND_UNUSED;
    end
  endtask

  // one input transfer, with a random gap in front; the model runs at acceptance
  task automatic offer(input blink_item_t it);
    lamp_result_t want;
    int unsigned  gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    s_tuser  = it.kind;
    s_tdata  = {3'b000, it.cnt, it.code, it.idx, it.stopped, it.esc, it.bench, it.ign,
                it.now};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    want = predict_lamp(it);
    if (it.typed) want = it.want;
    pending_lamp_q.push_back(want);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // wait until every result is in, then pad with idle cycles before any write
  task automatic settle();
    while (pending_lamp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t r, input logic [15:0] v);
    cfg_we   = 1'b1;
    cfg_addr = r;
    cfg_data = v;
    case (r)
      REG_SHORT_PULSE: cfg_short = v;
      REG_LONG_PULSE:  cfg_long  = v;
      REG_GAP:         cfg_gap   = v;
      REG_ESC_PERIOD:  cfg_flash = v;
      REG_KOEO_ENABLE: cfg_koeo  = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_timing(input logic [15:0] sp, input logic [15:0] lp,
                              input logic [15:0] gp, input logic [15:0] ep, input bit koeo);
    write_reg(REG_SHORT_PULSE, sp);
    write_reg(REG_LONG_PULSE, lp);
    write_reg(REG_GAP, gp);
    write_reg(REG_ESC_PERIOD, ep);
    write_reg(REG_KOEO_ENABLE, {15'd0, koeo});
  endtask

  task automatic run_random(input int n, input bit last_phase, input bit squeeze);
    blink_item_t it;
    int unsigned longest, dt_max;
    longest = cfg_short;
    if (cfg_long > longest) longest = cfg_long;
    if (cfg_gap > longest) longest = cfg_gap;
    if (cfg_flash > longest) longest = cfg_flash;
    // a few ticks per timer on average
    dt_max = longest / 3 + 3;
    for (int i = 0; i < n; i++) begin
      if (last_phase && i == n - CALM_ITEMS) calm = 1'b1;
      if (squeeze && i == 20) hold_req = 1'b1;
      draw_item(it, dt_max);
      offer(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // sender keeps offering, block fills and drops s_tready
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
        m_tready = 1'b1;
      end
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    lamp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lamp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("result %h with nothing pending", m_tdata);
      end else begin
        want = pending_lamp_q.pop_front();
        if (m_tdata[0] !== want.lamp || m_tdata[16:1] !== want.code ||
            m_tdata[18:17] !== want.ph) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected lamp=%0d code=%0d phase=%0d, got lamp=%0d code=%0d phase=%0d",
                     want.lamp, want.code, want.ph, m_tdata[0], m_tdata[16:1], m_tdata[18:17]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    blink_item_t plan[$];
    blink_item_t it;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    cfg_we   = 1'b0;
    cfg_addr = REG_SHORT_PULSE;
    cfg_data = '0;
    clock_ms   = $urandom;
    esc_left   = 0;
    bench_left = 0;
    off_left   = 0;
    clear_lamp_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows under reset timing (400 / 1500 / 400 / 200, bulb check off)
    // empty table, stopped engine, bulb check off: dark
    plan.push_back(with_result(row(KIND_TICK, 32'd0, F_IGN | F_STOP, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    // ignition off
    plan.push_back(with_result(row(KIND_TICK, 32'd5, 4'b0000, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    // unused kind with every field at its top value changes nothing
    plan.push_back(with_result(row(KIND_UNUSED, 32'hFFFF_FFFF, 4'b1111, 4'd15, 16'hFFFF,
                                   5'd31), 1'b0, 16'd0, PH_IDLE));
    // escalation starts lit, toggles only once strictly past the flash period
    plan.push_back(with_result(row(KIND_TICK, 32'd100, F_IGN | F_ESC, 4'd0, 16'd0, 5'd0),
                               1'b1, 16'd0, PH_IDLE));
    plan.push_back(with_result(row(KIND_TICK, 32'd300, F_IGN | F_ESC, 4'd0, 16'd0, 5'd0),
                               1'b1, 16'd0, PH_IDLE));
    plan.push_back(with_result(row(KIND_TICK, 32'd301, F_IGN | F_ESC, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    plan.push_back(with_result(row(KIND_TICK, 32'd350, F_IGN | F_STOP, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    // bench override holds the level, the tick after it starts from idle
    plan.push_back(with_result(row(KIND_TICK, 32'd360, F_IGN | F_BENCH, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    plan.push_back(with_result(row(KIND_TICK, 32'd370, F_IGN, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    // zero code, five-digit maximum, single digit
    plan.push_back(with_result(row(KIND_WRITE, 32'd0, 4'b0000, 4'd0, 16'd0, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    plan.push_back(with_result(row(KIND_WRITE, 32'd0, 4'b0000, 4'd1, 16'd65535, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    plan.push_back(with_result(row(KIND_WRITE, 32'd0, 4'b0000, 4'd2, 16'd7, 5'd0),
                               1'b0, 16'd0, PH_IDLE));
    plan.push_back(row(KIND_COUNT, 32'd0, 4'b0000, 4'd0, 16'd0, 5'd2));
    // blinking starts, pulse edge exactly at and just past its length
    plan.push_back(row(KIND_TICK, 32'd1000, F_IGN, 4'd0, 16'd0, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd1400, F_IGN, 4'd0, 16'd0, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd1401, F_IGN, 4'd0, 16'd0, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd1802, F_IGN, 4'd0, 16'd0, 5'd0));
    // active code overwritten while shown: restart at slot 0
    plan.push_back(row(KIND_COUNT, 32'd0, 4'b0000, 4'd0, 16'd0, 5'd3));
    plan.push_back(row(KIND_WRITE, 32'd0, 4'b0000, 4'd1, 16'd9, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd1900, F_IGN, 4'd0, 16'd0, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd2301, F_IGN, 4'd0, 16'd0, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd2702, F_IGN, 4'd0, 16'd0, 5'd0));
    // table emptied while blinking
    plan.push_back(row(KIND_COUNT, 32'd0, 4'b0000, 4'd0, 16'd0, 5'd0));
    plan.push_back(row(KIND_TICK, 32'd2710, F_IGN | F_STOP, 4'd0, 16'd0, 5'd0));
    foreach (plan[i]) offer(plan[i]);
    settle();

    // fill every slot so that any count reads written entries only
    for (int s = 0; s < SLOTS; s++) begin
      it = row(KIND_WRITE, $urandom, 4'($urandom), 4'(s), pick_code(), 5'($urandom));
      offer(it);
    end
    offer(row(KIND_COUNT, $urandom, 4'($urandom), 4'($urandom), 16'($urandom),
              5'($urandom_range(1, SLOTS))));
    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    // all timers zero, bulb check on, time wraps early
    settle();
    write_timing(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    clock_ms = 32'hFFFF_FF00;
    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    // all timers at their top value
    settle();
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    clock_ms = 32'hFFF0_0000;
    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    // short timers so codes cycle often, with the long output hold-off
    settle();
    write_timing(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), 1'b1);
    run_random(PHASE_ITEMS, 1'b0, 1'b1);

    // mixed small timers, last part without idling
    settle();
    write_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                 1'($urandom_range(0, 1)));
    run_random(PHASE_ITEMS, 1'b1, 1'b0);

    settle();
    repeat (64) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
